[rtl/core/sha256_byte_stream_hasher_defines.svh]
// Assertion macros shared by the hasher modules.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define SHA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/core/sha_pkg.sv]
// Package with types, round constants and SHA-256 helper functions.
`default_nettype none
package sha_pkg;
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam int QUEUE_DEPTH = 4;

	// One classified item as it travels through the queue.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LEN, ST_COMP, ST_FOLD, ST_OUT
	} back_state_t;

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction
	function automatic logic [31:0] sig0(input logic [31:0] x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction
	function automatic logic [31:0] sig1(input logic [31:0] x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction
	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction
	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction
endpackage
`default_nettype wire

[rtl/core/sha_front.sv]
// Front end: classifies input beats and queues them toward the back end.
`default_nettype none
`include "sha256_byte_stream_hasher_defines.svh"
module sha_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [7:0]       data_byte,
	input  wire  [1:0]       flags,
	output logic             q_valid,
	input  wire              q_pop,
	output sha_pkg::item_t   q_item
);
	localparam int AW = $clog2(sha_pkg::QUEUE_DEPTH);
	sha_pkg::item_t mem_q [sha_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	// Items with neither flag change nothing and are dropped here.
	assign s_tready = (cnt_q != (AW+1)'(sha_pkg::QUEUE_DEPTH));
	assign push = s_tvalid && s_tready && (flags != 2'b00);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_pop;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{data_byte: data_byte, has_byte: flags[0],
				end_of_message: flags[1]};
		end
	end

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`SHA_ASSERT_IMP(a_no_overflow, clk, arst_n, push, cnt_q < (AW+1)'(sha_pkg::QUEUE_DEPTH))
	`SHA_ASSERT_IMP(a_pop_valid, clk, arst_n, pop, cnt_q != '0)
	`SHA_ASSERT_NEXT(a_cnt_hold, clk, arst_n, !push && !pop, $stable(cnt_q))
endmodule
`default_nettype wire

[rtl/core/sha_back.sv]
// Back end: block buffer, padding sequencer, round engine and digest output.
`default_nettype none
`include "sha256_byte_stream_hasher_defines.svh"
module sha_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             q_valid,
	output logic            q_pop,
	input  sha_pkg::item_t  q_item,
	output logic            m_tvalid,
	input  wire             m_tready,
	output logic [31:0]     digest_word,
	output logic [2:0]      word_index,
	output logic            last_word
);
	sha_pkg::back_state_t st_q, st_d;
	logic [31:0] h_q [8];
	logic [31:0] a_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  lcnt_q;
	logic [2:0]  oidx_q;
	logic        eom_q;
	logic        pad_q;
	logic        fin_q;
	logic [63:0] bits;
	logic        put;
	logic [7:0]  put_byte;
	logic [31:0] wnew, t1, t2, wcur;

	assign bits = {len_q[60:0], 3'b000};
	assign wcur = w_q[0];
	assign wnew = w_q[0] + sha_pkg::sig0(w_q[1]) + w_q[9] + sha_pkg::sig1(w_q[14]);
	assign t1 = a_q[7] + sha_pkg::bsig1(a_q[4]) + ((a_q[4] & a_q[5]) ^ (~a_q[4] & a_q[6]))
		+ sha_pkg::ROUND_K[rnd_q] + wcur;
	assign t2 = sha_pkg::bsig0(a_q[0]) + ((a_q[0] & a_q[1]) ^ (a_q[0] & a_q[2]) ^
		(a_q[1] & a_q[2]));

	// Sequencer: decides which byte enters the block this cycle.
	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		put = 1'b0;
		put_byte = q_item.data_byte;
		unique case (st_q)
			sha_pkg::ST_IDLE: begin
				// Every queued item is taken here; a full block is compressed first.
				if (q_valid) begin
					q_pop = 1'b1;
					put = q_item.has_byte;
					if (q_item.has_byte && fill_q == 6'd63) st_d = sha_pkg::ST_COMP;
					else if (q_item.end_of_message) st_d = sha_pkg::ST_PAD;
				end
			end
			sha_pkg::ST_PAD: begin
				// First pad beat carries 0x80, the rest are zeros until byte 56.
				put = 1'b1;
				put_byte = pad_q ? 8'h00 : sha_pkg::PAD_BYTE;
				if (fill_q == 6'd63) st_d = sha_pkg::ST_COMP;
				else if (fill_q == sha_pkg::LEN_POS - 6'd1) st_d = sha_pkg::ST_LEN;
			end
			sha_pkg::ST_LEN: begin
				put = 1'b1;
				put_byte = bits[{3'd7 - lcnt_q, 3'b000} +: 8];
				if (lcnt_q == 3'd7) st_d = sha_pkg::ST_COMP;
			end
			sha_pkg::ST_COMP: begin
				if (rnd_q == 6'd63) st_d = sha_pkg::ST_FOLD;
			end
			sha_pkg::ST_FOLD: begin
				// After the length block the digest is ready; otherwise keep padding after an end of message, else take more bytes.
				if (fin_q) st_d = sha_pkg::ST_OUT;
				else if (eom_q) st_d = sha_pkg::ST_PAD;
				else st_d = sha_pkg::ST_IDLE;
			end
			sha_pkg::ST_OUT: begin
				if (m_tready && oidx_q == 3'd7) st_d = sha_pkg::ST_IDLE;
			end
			default: st_d = sha_pkg::ST_IDLE;
		endcase
	end

	// Output is taken straight from the hash registers.
	assign m_tvalid = (st_q == sha_pkg::ST_OUT);
	assign digest_word = h_q[oidx_q];
	assign word_index = oidx_q;
	assign last_word = (oidx_q == 3'd7);

	// Control and hash state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sha_pkg::ST_IDLE;
			fill_q <= '0;
			len_q <= '0;
			rnd_q <= '0;
			lcnt_q <= '0;
			oidx_q <= '0;
			eom_q <= 1'b0;
			pad_q <= 1'b0;
			fin_q <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
		end else begin
			st_q <= st_d;
			if (put) fill_q <= fill_q + 6'd1;
			if (st_q == sha_pkg::ST_IDLE && q_valid) begin
				if (q_item.has_byte) len_q <= len_q + 64'd1;
				if (q_item.end_of_message) eom_q <= 1'b1;
			end
			if (st_q == sha_pkg::ST_PAD) pad_q <= 1'b1;
			if (st_q == sha_pkg::ST_LEN) begin
				lcnt_q <= lcnt_q + 3'd1;
				if (lcnt_q == 3'd7) fin_q <= 1'b1;
			end
			if (st_q == sha_pkg::ST_COMP) rnd_q <= rnd_q + 6'd1;
			if (st_q == sha_pkg::ST_FOLD) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + a_q[i];
			end
			if (st_q == sha_pkg::ST_OUT && m_tready) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					len_q <= '0;
					eom_q <= 1'b0;
					pad_q <= 1'b0;
					fin_q <= 1'b0;
					for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
				end
			end
		end
	end

	// Block words and working variables.
	always_ff @(posedge clk) begin
		if (put) begin
			w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], put_byte};
		end
		if (st_q != sha_pkg::ST_COMP && st_d == sha_pkg::ST_COMP) begin
			for (int i = 0; i < 8; i++) a_q[i] <= h_q[i];
		end
		if (st_q == sha_pkg::ST_COMP) begin
			// One round per cycle; the schedule window shifts by one word.
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			a_q[7] <= a_q[6]; a_q[6] <= a_q[5]; a_q[5] <= a_q[4];
			a_q[4] <= a_q[3] + t1;
			a_q[3] <= a_q[2]; a_q[2] <= a_q[1]; a_q[1] <= a_q[0];
			a_q[0] <= t1 + t2;
		end
	end

	`SHA_ASSERT_IMP(a_out_in_state, clk, arst_n, m_tvalid, st_q == sha_pkg::ST_OUT)
	`SHA_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, $stable(oidx_q))
	`SHA_ASSERT_IMP(a_rnd_range, clk, arst_n, st_q == sha_pkg::ST_FOLD, rnd_q == 6'd0)
endmodule
`default_nettype wire

[rtl/core/sha256_byte_stream_hasher.sv]
// Each 64-byte block takes 64 byte loads, 64 rounds and one fold; the back end takes no new
// bytes while it compresses, and an accepted beat waits in the front queue until it loads.
// After the end-of-message beat, pad and length bytes load one per cycle between compressions,
// and the digest is ready once the last block is folded; a pad byte past byte 55 adds a block.
// The digest leaves as eight beats, one per cycle when accepted; reset (arst_n low) clears
// the queue and loads the initial hash values at once.
`default_nettype none
module sha256_byte_stream_hasher (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // data_byte[7:0]
	input  wire         s_tlast,   // end_of_message
	input  wire         s_tuser,   // has_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast    // last_word
);
	logic q_valid, q_pop;
	sha_pkg::item_t q_item;
	logic [31:0] dw;
	logic [2:0] wi;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.data_byte(s_tdata), .flags({s_tlast, s_tuser}),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	sha_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .digest_word(dw),
		.word_index(wi), .last_word(m_tlast)
	);

	assign m_tdata = {5'b00000, wi, dw};
endmodule
`default_nettype wire

[tb/tb_sha256_byte_stream_hasher.sv]
// Self-checking testbench for the SHA-256 byte stream hasher.
`timescale 1ns / 100ps
`default_nettype none
module tb_sha256_byte_stream_hasher;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	// One digest word as it is expected on the output.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha_pkg::item_t pending_items[$];
	digest_beat_t   expected_digests[$];
	int             errors = 0;
	int             idle_cycles = 0;
	bit             hold_off_req = 0;
	int             burst_left = 0;
	int             gap_left = 0;

	// Predictor state.
	logic [31:0] hash_state[8];
	logic [7:0]  block_bytes[64];
	int          block_fill;
	logic [63:0] message_bytes;

	sha256_byte_stream_hasher i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// Run the 64 rounds over the current block and fold into the hash state.
	task automatic compress_current_block();
		logic [31:0] w[64];
		logic [31:0] r[8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		r = hash_state;
		for (int i = 0; i < 64; i++) begin
			t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
				+ ((r[4] & r[5]) ^ (~r[4] & r[6])) + sha_pkg::ROUND_K[i] + w[i];
			t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
				+ ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
			r[7] = r[6]; r[6] = r[5]; r[5] = r[4];
			r[4] = r[3] + t1;
			r[3] = r[2]; r[2] = r[1]; r[1] = r[0];
			r[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += r[i];
	endtask

	task automatic append_byte(input logic [7:0] b);
		block_bytes[block_fill] = b;
		block_fill++;
		if (block_fill == 64) begin
			compress_current_block();
			block_fill = 0;
		end
	endtask

	task automatic reset_hash_state();
		hash_state = sha_pkg::INIT_H;
		block_fill = 0;
		message_bytes = '0;
	endtask

	// Apply one accepted beat; on end of message queue the eight digest words.
	task automatic predict_digest(input sha_pkg::item_t it);
		logic [63:0] bit_len;
		digest_beat_t d;
		if (it.has_byte) begin
			append_byte(it.data_byte);
			message_bytes++;
		end
		if (it.end_of_message) begin
			bit_len = message_bytes << 3;
			append_byte(sha_pkg::PAD_BYTE);
			while (block_fill != int'(sha_pkg::LEN_POS)) append_byte(8'h00);
			for (int i = 0; i < 8; i++) append_byte(bit_len[63-8*i -: 8]);
			for (int i = 0; i < 8; i++) begin
				d.digest_word = hash_state[i];
				d.word_index = 3'(i);
				d.last_word = (i == 7);
				expected_digests.insert(expected_digests.size(), d);
			end
			reset_hash_state();
		end
	endtask

	function automatic sha_pkg::item_t make_item(input logic [7:0] b, input bit hb,
		input bit eom);
		sha_pkg::item_t it;
		it.data_byte = b;
		it.has_byte = hb;
		it.end_of_message = eom;
		return it;
	endfunction

	task automatic add_item(input sha_pkg::item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	// Queue a well-formed message of len bytes with random content.
	task automatic queue_message(input int len);
		for (int i = 0; i < len; i++)
			add_item(make_item(8'($urandom), 1'b1, i == len - 1));
		if (len == 0) add_item(make_item(8'($urandom), 1'b0, 1'b1));
	endtask

	// Driver: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			s_tuser <= 1'b0;
		end else begin
			automatic bit done = s_tvalid && s_tready;
			automatic sha_pkg::item_t nxt;
			if (done) predict_digest(pending_items.pop_front());
			if (!s_tvalid || done) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items[0];
					s_tvalid <= 1'b1;
					s_tdata <= nxt.data_byte;
					s_tuser <= nxt.has_byte;
					s_tlast <= nxt.end_of_message;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off_req) begin
			m_tready <= 1'b0;
			for (int i = 0; i < 400; i++) @(posedge clk);
			hold_off_req <= 1'b0;
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 9) < 7);
		end
	end

	// Monitor: compare each output beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			automatic digest_beat_t got, want;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
			if (m_tvalid && m_tready) begin
				got.digest_word = m_tdata[31:0];
				got.word_index = m_tdata[34:32];
				got.last_word = m_tlast;
				if (expected_digests.size() == 0) begin
					$display("%0t: unexpected beat %h", $time, got);
					errors++;
				end else begin
					want = expected_digests.pop_front();
					if (got.digest_word !== want.digest_word) begin
						$display("%0t: digest_word expected %h actual %h", $time,
							want.digest_word, got.digest_word);
						errors++;
					end
					if (got.word_index !== want.word_index) begin
						$display("%0t: word_index expected %0d actual %0d", $time,
							want.word_index, got.word_index);
						errors++;
					end
					if (got.last_word !== want.last_word) begin
						$display("%0t: last_word expected %b actual %b", $time,
							want.last_word, got.last_word);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int lens[] = '{0, 1, 56, 64};
		reset_hash_state();
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty message, byte extremes, padding boundaries, idle beats.
		add_item(make_item(8'h00, 1'b0, 1'b0));
		add_item(make_item(8'hff, 1'b0, 1'b1));
		add_item(make_item(8'h00, 1'b1, 1'b0));
		add_item(make_item(8'h5a, 1'b0, 1'b0));
		add_item(make_item(8'hff, 1'b1, 1'b1));
		add_item(make_item(8'haa, 1'b1, 1'b0));
		add_item(make_item(8'h55, 1'b0, 1'b1));
		foreach (lens[i]) queue_message(lens[i]);

		// Long hold-off while the sender keeps offering items.
		hold_off_req = 1'b1;
		queue_message(10);

		// Random short messages, with stray idle beats mixed in.
		for (int n = 0; n < 6; n++) begin
			int len;
			len = $urandom_range(0, 8);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 7) == 0)
					add_item(make_item(8'($urandom), 1'b0, 1'b0));
				add_item(make_item(8'($urandom), 1'b1, 1'b0));
			end
			add_item(make_item(8'($urandom), 1'($urandom), 1'b1));
		end

		wait (pending_items.size() == 0 && expected_digests.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_digests.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
